FILE: sv/prn_pkg.sv
`timescale 1ns / 1ps
package prn_pkg;
	localparam int MAX_IN_LEN = 256;
	localparam int MAX_OUT_LEN = 128;
	localparam int VALUE_BITS = 10;
	localparam int IN_AW = $clog2(MAX_IN_LEN);
	localparam int OUT_AW = $clog2(MAX_OUT_LEN);
	localparam int CNT_W = IN_AW + 1;
	localparam int N_W = OUT_AW + 1;
	localparam logic [7:0] OUT_LEN_RESET = 8'd40;
	localparam logic [0:0] REG_OUT_LENGTH = 1'b0;

	typedef struct packed {
		logic [9:0] sample_value;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [6:0]        first_index;
		logic signed [7:0] feature_a;
		logic signed [7:0] feature_b;
		logic              has_b;
		logic              last_result;
	} out_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] len;
	} job_t;
endpackage

FILE: sv/prn_divider.sv
`timescale 1ns / 1ps
module prn_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] num,
	input  logic [15:0] den,
	output logic        done,
	output logic [23:0] quo
);
	logic [23:0] q_q;
	logic [16:0] r_q;
	logic [15:0] d_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;

	assign trial = {r_q[15:0], q_q[23]};
	assign quo = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[22:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[22:0], 1'b0};
			end
		end
	end
endmodule

FILE: sv/prn_front.sv
`timescale 1ns / 1ps
module prn_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  prn_pkg::in_word_t            in_word,
	output logic                         wr_en,
	output logic [prn_pkg::IN_AW-1:0]    wr_addr,
	output logic [prn_pkg::VALUE_BITS-1:0] wr_data,
	output logic                         job_valid,
	input  logic                         job_stall,
	output prn_pkg::job_t                job
);
	logic [prn_pkg::CNT_W-1:0] cnt_q;
	logic                      acc;
	logic                      full;

	assign full = cnt_q == prn_pkg::CNT_W'(prn_pkg::MAX_IN_LEN);
	// hold new words while a finished profile waits or the back end still reads the store
	assign in_stall = job_valid || job_stall;
	assign acc = in_valid && !in_stall;
	assign wr_en = acc && !full;
	assign wr_addr = cnt_q[prn_pkg::IN_AW-1:0];
	assign wr_data = in_word.sample_value[prn_pkg::VALUE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			job_valid <= 1'b0;
			job <= '0;
		end else begin
			if (job_valid && !job_stall) job_valid <= 1'b0;
			if (acc) begin
				if (in_word.is_last) begin
					job_valid <= 1'b1;
					job.len <= full ? cnt_q : cnt_q + 1'b1;
					cnt_q <= '0;
				end else if (!full) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end
endmodule

FILE: sv/prn_back.sv
`timescale 1ns / 1ps
module prn_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [prn_pkg::IN_AW-1:0]      wr_addr,
	input  logic [prn_pkg::VALUE_BITS-1:0] wr_data,
	input  logic                           job_valid,
	output logic                           job_stall,
	input  prn_pkg::job_t                  job,
	input  logic [7:0]                     out_length,
	output logic                           out_valid,
	input  logic                           out_stall,
	output prn_pkg::out_word_t             out_word
);
	localparam int VB = prn_pkg::VALUE_BITS;
	localparam logic [3:0] S_IDLE = 4'd0, S_RA = 4'd1, S_RAW = 4'd2, S_RB = 4'd3,
		S_RBW = 4'd4, S_DIV = 4'd5, S_DIVW = 4'd6, S_NRD = 4'd7, S_NRW = 4'd8,
		S_NDIV = 4'd9, S_NDW = 4'd10, S_EMIT = 4'd11, S_STEP = 4'd12;

	logic [VB-1:0] prof_mem [prn_pkg::MAX_IN_LEN];
	logic [VB-1:0] res_mem [prn_pkg::MAX_OUT_LEN];
	logic [VB-1:0] prof_rd_q, res_rd_q;
	logic [prn_pkg::IN_AW-1:0] prof_addr;
	logic [prn_pkg::OUT_AW-1:0] res_addr;

	logic [3:0] state_q;
	logic [prn_pkg::CNT_W-1:0] len_q;
	logic [prn_pkg::N_W-1:0] n_q, i_q;
	logic [prn_pkg::CNT_W-1:0] lo_q;
	logic [prn_pkg::CNT_W:0] rem_q;
	logic [prn_pkg::CNT_W:0] rem_step;
	logic [VB-1:0] a_q, min_q, max_q;
	logic signed [7:0] fa_q;
	logic signed [7:0] feat;
	logic second_q;

	logic        dstart;
	logic [23:0] dnum;
	logic [15:0] dden;
	logic        ddone;
	logic [23:0] dquo;

	logic [prn_pkg::N_W-1:0] n_eff;
	logic [prn_pkg::N_W-1:0] nm1;
	logic [VB:0] range;
	logic [VB+8:0] nnum;
	logic nneg;
	logic signed [VB+9:0] sdiff;

	prn_divider u_div (.clk, .arst_n, .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo));

	always_comb begin
		if (out_length < 8'd2) n_eff = prn_pkg::N_W'(2);
		else if (out_length > 8'(prn_pkg::MAX_OUT_LEN))
			n_eff = prn_pkg::N_W'(prn_pkg::MAX_OUT_LEN);
		else n_eff = prn_pkg::N_W'(out_length);
	end
	assign nm1 = n_q - 1'b1;
	assign range = {1'b0, max_q} - {1'b0, min_q};
	assign sdiff = (VB+10)'(200 * $signed({1'b0, res_rd_q} - {1'b0, min_q}) -
		100 * $signed({1'b0, range}));
	assign nneg = sdiff < 0;
	assign nnum = (VB+9)'(nneg ? -sdiff : sdiff);
	assign feat = (range == 0) ? 8'sd0 : (nneg ? -8'(dquo) : 8'(dquo));
	// advance position by len-1 in units of n-1
	assign rem_step = rem_q + (prn_pkg::CNT_W+1)'(len_q - 1'b1);

	assign job_stall = state_q != S_IDLE;

	always_comb begin
		prof_addr = lo_q[prn_pkg::IN_AW-1:0];
		if (state_q == S_RB || state_q == S_RBW) prof_addr = prn_pkg::IN_AW'(lo_q + 1'b1);
		res_addr = i_q[prn_pkg::OUT_AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) prof_mem[wr_addr] <= wr_data;
		prof_rd_q <= prof_mem[prof_addr];
		if (state_q == S_DIVW && ddone || state_q == S_RAW && (rem_q == 0 ||
			lo_q + 1'b1 > len_q - 1'b1))
			res_mem[res_addr] <= (state_q == S_DIVW) ? dquo[VB-1:0] : prof_rd_q;
		res_rd_q <= res_mem[res_addr];
	end

	always_comb begin
		dstart = 1'b0;
		dnum = '0;
		dden = 16'(nm1);
		if (state_q == S_DIV) begin
			dstart = 1'b1;
			dnum = 24'(a_q) * 24'(nm1) + 24'(rem_q) * 24'(prof_rd_q) - 24'(rem_q) * 24'(a_q);
		end else if (state_q == S_NRW) begin
			dstart = range != 0;
			dnum = 24'(nnum);
			dden = 16'(range);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			min_q <= '1;
			max_q <= '0;
			second_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (job_valid) begin
					len_q <= job.len;
					n_q <= n_eff;
					i_q <= '0;
					lo_q <= '0;
					rem_q <= '0;
					state_q <= S_RA;
				end
				S_RA: state_q <= S_RAW;
				S_RAW: begin
					a_q <= prof_rd_q;
					if (rem_q == 0 || lo_q + 1'b1 > len_q - 1'b1) begin
						if (prof_rd_q < min_q) min_q <= prof_rd_q;
						if (prof_rd_q > max_q) max_q <= prof_rd_q;
						state_q <= S_DIVW;
					end else state_q <= S_RB;
				end
				S_RB: state_q <= S_RBW;
				S_RBW: state_q <= S_DIV;
				S_DIV: state_q <= S_DIVW;
				S_DIVW: if (ddone || rem_q == 0 || lo_q + 1'b1 > len_q - 1'b1) begin
					if (ddone) begin
						if (dquo[VB-1:0] < min_q) min_q <= dquo[VB-1:0];
						if (dquo[VB-1:0] > max_q) max_q <= dquo[VB-1:0];
					end
					if (i_q + 1'b1 == n_q) begin
						i_q <= '0;
						second_q <= 1'b0;
						state_q <= S_NRD;
					end else begin
						i_q <= i_q + 1'b1;
						rem_q <= rem_step;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (rem_q >= (prn_pkg::CNT_W+1)'(nm1)) begin
						rem_q <= rem_q - (prn_pkg::CNT_W+1)'(nm1);
						lo_q <= lo_q + 1'b1;
					end else state_q <= S_RA;
				end
				S_NRD: if (!out_valid || !out_stall) state_q <= S_NRW;
				S_NRW: state_q <= (range != 0) ? S_NDW : S_EMIT;
				S_NDW: if (ddone) state_q <= S_EMIT;
				S_EMIT: begin
					if (!second_q) begin
						fa_q <= feat;
						if (i_q + 1'b1 == n_q) begin
							out_word.first_index <= 7'(i_q);
							out_word.feature_a <= feat;
							out_word.feature_b <= '0;
							out_word.has_b <= 1'b0;
							out_word.last_result <= 1'b1;
							out_valid <= 1'b1;
							state_q <= S_IDLE;
							min_q <= '1;
							max_q <= '0;
						end else begin
							second_q <= 1'b1;
							i_q <= i_q + 1'b1;
							state_q <= S_NRD;
						end
					end else begin
						out_word.first_index <= 7'(i_q - 1'b1);
						out_word.feature_a <= fa_q;
						out_word.feature_b <= feat;
						out_word.has_b <= 1'b1;
						out_word.last_result <= i_q + 1'b1 == n_q;
						out_valid <= 1'b1;
						second_q <= 1'b0;
						if (i_q + 1'b1 == n_q) begin
							state_q <= S_IDLE;
							min_q <= '1;
							max_q <= '0;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_NRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/profile_resample_normalize_top.sv
`timescale 1ns / 1ps
// Profile words load one per cycle while not stalled into a 256-entry store (words
// past the 256th are dropped); a word with is_last hands the profile to the back end
// and new words stall until its last pair has been emitted. Each of the n points is
// resampled by interpolating through the 24-step serial divider or by copying a
// stored word, stepping over stored words in between; each point is then normalised
// with the same divider (skipped when all points are equal) and a pair goes out for
// every two points (the last one alone for odd n), waiting while the output stalls.
module profile_resample_normalize_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  prn_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output prn_pkg::out_word_t   out_word,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	logic [7:0] out_len_q;
	logic wr_en, job_valid, job_stall;
	logic [prn_pkg::IN_AW-1:0] wr_addr;
	logic [prn_pkg::VALUE_BITS-1:0] wr_data;
	prn_pkg::job_t job;

	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == {prn_pkg::REG_OUT_LENGTH, 1'b0}) ? 32'(out_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_len_q <= prn_pkg::OUT_LEN_RESET;
		else if (psel && penable && pwrite &&
			paddr == {prn_pkg::REG_OUT_LENGTH, 1'b0}) out_len_q <= pwdata[7:0];
	end

	prn_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_word, .wr_en,
		.wr_addr, .wr_data, .job_valid, .job_stall, .job);

	prn_back u_back (.clk, .arst_n, .wr_en, .wr_addr, .wr_data, .job_valid,
		.job_stall, .job, .out_length(out_len_q), .out_valid, .out_stall, .out_word);
endmodule
